// ===== sv/gdr_pkg.sv =====
// Shared types, constants and helpers of the grid ray caster.
// No dependencies; the controller, datapath and top files refer to it by scoped names.
package gdr_pkg;

  // Default geometry and fixed point
  localparam int MAP_SIZE_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_H = 3'd5;

  // Reset values of the camera and screen registers
  localparam logic [20:0]        POS_X_RST = 21'd1441792;
  localparam logic [20:0]        POS_Y_RST = 21'd786432;
  localparam logic signed [17:0] DIR_X_RST = -18'sd65536;
  localparam logic signed [17:0] DIR_Y_RST = 18'sd0;
  localparam logic [11:0]        SCR_W_RST = 12'd1024;
  localparam logic [11:0]        SCR_H_RST = 12'd768;
  localparam logic [11:0]        SCR_MAX   = 12'd2048;

  // Input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [4:0]  cell_col;
    logic [4:0]  cell_row;
    logic [3:0]  cell_code;
    logic [10:0] column;
  } in_item_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic [10:0] draw_start;
    logic [10:0] draw_end;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        y_side;
    logic        hit;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [5:0] {
    OP_NONE, OP_DIV_CAMX, OP_CAP_CAMX, OP_MUL_KC, OP_T, OP_MUL_DYT, OP_RX,
    OP_MUL_DXT, OP_RY, OP_MUL_RX2, OP_ACC, OP_MUL_RY2, OP_SQ_INIT, OP_SQ_STEP,
    OP_DIV_NX, OP_CAP_NX, OP_DIV_NY, OP_CAP_NY, OP_DIV_DX, OP_CAP_DX,
    OP_DIV_DY, OP_CAP_DY, OP_MUL_SXH, OP_SXH, OP_MUL_SXL, OP_SXL,
    OP_MUL_SYH, OP_SYH, OP_MUL_SYL, OP_SYL, OP_STEP, OP_DIST, OP_DIV_SPAN,
    OP_CAP_SPAN, OP_FIN, OP_MISS
  } op_e;

  typedef struct packed {
    op_e  op;
    logic take;   // input beat accepted this cycle
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic div_done;
    logic sq_done;
    logic len_zero;
    logic cam_oob;
    logic step_lim;
    logic oob;
    logic code_nz;
    logic out_free;
  } status_t;

  // Wall colour by code, packed as {red, green, blue}
  function automatic logic [23:0] color_f(input logic [3:0] code);
    logic [23:0] c;
    case (code)
      4'd1:    c = 24'hFF0000;
      4'd2:    c = 24'h00FF00;
      4'd3:    c = 24'h0000FF;
      4'd4:    c = 24'hFFFFFF;
      4'd5:    c = 24'hFF00FF;
      default: c = 24'hFFFF00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/gdr_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gdr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gdr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// The caller gives the number of significant numerator bits. No dependencies.
module gdr_div #(
  parameter int DW = 42
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DW-1:0]          num_i,
  input  logic [DW-1:0]          den_i,
  input  logic [$clog2(DW+1)-1:0] iters_i,
  output logic                   done_o,
  output logic [DW-1:0]          quot_o
);

  localparam int IW = $clog2(DW+1);

  logic          act_q, act_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   trial;

  assign done_o = act_q && (cnt_q == '0);
  assign quot_o = quo_q;

  // One shift-subtract step per cycle
  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    trial = {rem_q[DW-1:0], quo_q[DW-1]};
    if (start_i) begin
      act_d = 1'b1;
      cnt_d = iters_i;
      rem_d = '0;
      quo_d = num_i << (IW'(DW) - iters_i);
      den_d = den_i;
    end else if (act_q) begin
      if (cnt_q == '0) begin
        act_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[DW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      act_q <= act_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

endmodule

// ===== sv/gdr_ctrl.sv =====
// Sequencer of the ray caster: steps the datapath through one cast.
// Depends on gdr_pkg for the command and status structs.
module gdr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gdr_pkg::status_t status_i,
  output gdr_pkg::cmd_t    cmd_o,
  output logic             in_ready_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_CAMX_GO, S_CAMX_WAIT, S_MUL_KC, S_T, S_MUL_DYT, S_RX, S_MUL_DXT,
    S_RY, S_MUL_RX2, S_ACC, S_MUL_RY2, S_SQ_INIT, S_SQ_STEP, S_LEN_CHK,
    S_NX_GO, S_NX_WAIT, S_NY_GO, S_NY_WAIT, S_DX_GO, S_DX_WAIT, S_DY_GO,
    S_DY_WAIT, S_MUL_SXH, S_SXH, S_MUL_SXL, S_SXL, S_MUL_SYH, S_SYH,
    S_MUL_SYL, S_SYL, S_STEP, S_TEST, S_DIST, S_SPAN_GO, S_SPAN_WAIT,
    S_HIT_OUT, S_MISS_OUT
  } state_e;

  state_e         state_q, state_d;
  gdr_pkg::op_e   op;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.take = in_ready_o && status_i.in_valid;
  assign cmd_o.op   = op;

  // Next state and the operation of the current state
  always_comb begin
    state_d = state_q;
    op      = gdr_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (status_i.in_valid && status_i.in_kind == gdr_pkg::KIND_CAST) begin
          state_d = S_CAMX_GO;
        end
      end
      S_CAMX_GO:   begin op = gdr_pkg::OP_DIV_CAMX; state_d = S_CAMX_WAIT; end
      S_CAMX_WAIT: begin
        op = gdr_pkg::OP_CAP_CAMX;
        if (status_i.div_done) state_d = S_MUL_KC;
      end
      S_MUL_KC:  begin op = gdr_pkg::OP_MUL_KC;  state_d = S_T;       end
      S_T:       begin op = gdr_pkg::OP_T;       state_d = S_MUL_DYT; end
      S_MUL_DYT: begin op = gdr_pkg::OP_MUL_DYT; state_d = S_RX;      end
      S_RX:      begin op = gdr_pkg::OP_RX;      state_d = S_MUL_DXT; end
      S_MUL_DXT: begin op = gdr_pkg::OP_MUL_DXT; state_d = S_RY;      end
      S_RY:      begin op = gdr_pkg::OP_RY;      state_d = S_MUL_RX2; end
      S_MUL_RX2: begin op = gdr_pkg::OP_MUL_RX2; state_d = S_ACC;     end
      S_ACC:     begin op = gdr_pkg::OP_ACC;     state_d = S_MUL_RY2; end
      S_MUL_RY2: begin op = gdr_pkg::OP_MUL_RY2; state_d = S_SQ_INIT; end
      S_SQ_INIT: begin op = gdr_pkg::OP_SQ_INIT; state_d = S_SQ_STEP; end
      S_SQ_STEP: begin
        op = gdr_pkg::OP_SQ_STEP;
        if (status_i.sq_done) state_d = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        state_d = (status_i.len_zero || status_i.cam_oob) ? S_MISS_OUT : S_NX_GO;
      end
      S_NX_GO:   begin op = gdr_pkg::OP_DIV_NX; state_d = S_NX_WAIT; end
      S_NX_WAIT: begin
        op = gdr_pkg::OP_CAP_NX;
        if (status_i.div_done) state_d = S_NY_GO;
      end
      S_NY_GO:   begin op = gdr_pkg::OP_DIV_NY; state_d = S_NY_WAIT; end
      S_NY_WAIT: begin
        op = gdr_pkg::OP_CAP_NY;
        if (status_i.div_done) state_d = S_DX_GO;
      end
      S_DX_GO:   begin op = gdr_pkg::OP_DIV_DX; state_d = S_DX_WAIT; end
      S_DX_WAIT: begin
        op = gdr_pkg::OP_CAP_DX;
        if (status_i.div_done) state_d = S_DY_GO;
      end
      S_DY_GO:   begin op = gdr_pkg::OP_DIV_DY; state_d = S_DY_WAIT; end
      S_DY_WAIT: begin
        op = gdr_pkg::OP_CAP_DY;
        if (status_i.div_done) state_d = S_MUL_SXH;
      end
      S_MUL_SXH: begin op = gdr_pkg::OP_MUL_SXH; state_d = S_SXH;     end
      S_SXH:     begin op = gdr_pkg::OP_SXH;     state_d = S_MUL_SXL; end
      S_MUL_SXL: begin op = gdr_pkg::OP_MUL_SXL; state_d = S_SXL;     end
      S_SXL:     begin op = gdr_pkg::OP_SXL;     state_d = S_MUL_SYH; end
      S_MUL_SYH: begin op = gdr_pkg::OP_MUL_SYH; state_d = S_SYH;     end
      S_SYH:     begin op = gdr_pkg::OP_SYH;     state_d = S_MUL_SYL; end
      S_MUL_SYL: begin op = gdr_pkg::OP_MUL_SYL; state_d = S_SYL;     end
      S_SYL:     begin op = gdr_pkg::OP_SYL;     state_d = S_STEP;    end
      // grid walk: step, then test the cell read back
      S_STEP: begin
        if (status_i.step_lim) begin
          state_d = S_MISS_OUT;
        end else begin
          op      = gdr_pkg::OP_STEP;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.oob)          state_d = S_MISS_OUT;
        else if (status_i.code_nz) state_d = S_DIST;
        else                       state_d = S_STEP;
      end
      S_DIST:    begin op = gdr_pkg::OP_DIST;     state_d = S_SPAN_GO; end
      S_SPAN_GO: begin op = gdr_pkg::OP_DIV_SPAN; state_d = S_SPAN_WAIT; end
      S_SPAN_WAIT: begin
        op = gdr_pkg::OP_CAP_SPAN;
        if (status_i.div_done) state_d = S_HIT_OUT;
      end
      S_HIT_OUT: begin
        op = gdr_pkg::OP_FIN;
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_MISS_OUT: begin
        op = gdr_pkg::OP_MISS;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/gdr_dp.sv =====
// Datapath of the ray caster: configuration registers, shared multiplier,
// square root, divider, grid walk, wall map and output register.
// Depends on gdr_pkg, gdr_div and gdr_ram.
module gdr_dp #(
  parameter int MAP_SIZE  = gdr_pkg::MAP_SIZE_DEF,
  parameter int FRAC_BITS = gdr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  gdr_pkg::in_item_t                in_item_i,
  output gdr_pkg::out_item_t               out_item_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  gdr_pkg::cmd_t                    cmd_i,
  output gdr_pkg::status_t                 status_o
);

  localparam int F     = FRAC_BITS;
  localparam int MW    = F + 4;            // multiplier operand width
  localparam int PW    = 2 * MW;
  localparam int DW    = 2 * F + 10;       // divider and distance width
  localparam int IW    = $clog2(DW + 1);
  localparam int SW    = 2 * F + 6;        // square root width
  localparam int AW    = $clog2(MAP_SIZE * MAP_SIZE);
  localparam int CW    = (($clog2(MAP_SIZE + 1) > 5) ? $clog2(MAP_SIZE + 1) : 5) + 1;
  localparam int STW   = $clog2(2 * MAP_SIZE + 5);
  localparam int SH_UP = (F >= 16) ? F - 16 : 0;
  localparam int SH_DN = (F < 16) ? 16 - F : 0;
  localparam int DIRW  = (F >= 16) ? F + 3 : 18;
  localparam int FRW   = (F >= 16) ? F : 16;
  localparam longint K = (66 * (longint'(1) << F) + 50) / 100;
  localparam logic [STW-1:0] STEP_MAX = STW'(2 * MAP_SIZE + 2);

  // Camera registers rescaled to the internal fraction width
  function automatic logic signed [F+2:0] dir_f(input logic signed [17:0] v);
    logic signed [DIRW-1:0] e;
    logic signed [DIRW-1:0] m;
    e = DIRW'(v);
    if (F >= 16) m = e <<< SH_UP;
    else         m = (e < 0) ? -((-e) >>> SH_DN) : (e >>> SH_DN);
    return (F + 3)'(m);
  endfunction

  function automatic logic [F-1:0] frac_f(input logic [15:0] v);
    logic [FRW-1:0] e;
    e = FRW'(v);
    if (F >= 16) e = e << SH_UP;
    else         e = e >> SH_DN;
    return F'(e);
  endfunction

  // Division by 2^F truncating toward zero
  function automatic logic signed [PW-1:0] shr_f(input logic signed [PW-1:0] p);
    return (p < 0) ? -((-p) >>> F) : (p >>> F);
  endfunction

  // ---------------- configuration registers ----------------
  logic [20:0]        pos_x_q, pos_y_q;
  logic signed [17:0] dir_x_q, dir_y_q;
  logic [11:0]        scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= gdr_pkg::POS_X_RST;
      pos_y_q <= gdr_pkg::POS_Y_RST;
      dir_x_q <= gdr_pkg::DIR_X_RST;
      dir_y_q <= gdr_pkg::DIR_Y_RST;
      scr_w_q <= gdr_pkg::SCR_W_RST;
      scr_h_q <= gdr_pkg::SCR_H_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gdr_pkg::REG_POS_X: pos_x_q <= cfg_data_i[20:0];
        gdr_pkg::REG_POS_Y: pos_y_q <= cfg_data_i[20:0];
        gdr_pkg::REG_DIR_X: dir_x_q <= $signed(cfg_data_i[17:0]);
        gdr_pkg::REG_DIR_Y: dir_y_q <= $signed(cfg_data_i[17:0]);
        gdr_pkg::REG_SCR_W: scr_w_q <= cfg_data_i[11:0];
        gdr_pkg::REG_SCR_H: scr_h_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Screen sizes clamped to 1..2048, column clamped below width
  logic [11:0] w, h;
  logic [10:0] c;
  gdr_pkg::in_item_t item_q;

  assign w = (scr_w_q == '0) ? 12'd1 : ((scr_w_q > gdr_pkg::SCR_MAX) ? gdr_pkg::SCR_MAX : scr_w_q);
  assign h = (scr_h_q == '0) ? 12'd1 : ((scr_h_q > gdr_pkg::SCR_MAX) ? gdr_pkg::SCR_MAX : scr_h_q);
  assign c = ({1'b0, item_q.column} < w) ? item_q.column : 11'(w - 12'd1);

  logic signed [F+2:0] dx, dy;
  logic [F-1:0]        frx, fry;
  assign dx  = dir_f(dir_x_q);
  assign dy  = dir_f(dir_y_q);
  assign frx = frac_f(pos_x_q[15:0]);
  assign fry = frac_f(pos_y_q[15:0]);

  // ---------------- working registers ----------------
  logic signed [F+1:0] camx_q, t_q, nx_q, ny_q;
  logic signed [F+2:0] rx_q, ry_q;
  logic signed [PW-1:0] prod_q;
  logic [SW-1:0] acc_q, sq_v_q, sq_res_q, sq_bit_q;
  logic [DW-1:0] dxd_q, dyd_q, sx_q, sy_q, dist_q;
  logic signed [CW-1:0] mx_q, my_q;
  logic [STW-1:0] steps_q;
  logic side_q, oob_q;
  logic [12:0] span_q;
  gdr_pkg::out_item_t out_q;
  gdr_pkg::out_item_t miss_item;
  logic out_valid_q;

  // Divider operand select
  logic          div_start;
  logic [DW-1:0] div_num, div_den, div_q;
  logic [IW-1:0] div_iters;
  logic          div_done;
  logic signed [12:0] cdiff;
  logic [11:0]   cmag;

  assign cdiff = $signed({1'b0, c, 1'b0}) - $signed({1'b0, w});
  assign cmag  = (cdiff < 0) ? 12'(-cdiff) : 12'(cdiff);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    case (cmd_i.op)
      gdr_pkg::OP_DIV_CAMX: begin
        div_start = 1'b1;
        div_num   = DW'(cmag) << F;
        div_den   = DW'(w);
        div_iters = IW'(F + 12);
      end
      gdr_pkg::OP_DIV_NX: begin
        div_start = 1'b1;
        div_num   = DW'((rx_q < 0) ? -rx_q : rx_q) << F;
        div_den   = DW'(sq_res_q[F+2:0]);
        div_iters = IW'(2 * F + 3);
      end
      gdr_pkg::OP_DIV_NY: begin
        div_start = 1'b1;
        div_num   = DW'((ry_q < 0) ? -ry_q : ry_q) << F;
        div_den   = DW'(sq_res_q[F+2:0]);
        div_iters = IW'(2 * F + 3);
      end
      gdr_pkg::OP_DIV_DX: begin
        div_start = 1'b1;
        div_num   = DW'(1) << (2 * F);
        div_den   = DW'((nx_q < 0) ? -nx_q : nx_q);
        div_iters = IW'(2 * F + 1);
      end
      gdr_pkg::OP_DIV_DY: begin
        div_start = 1'b1;
        div_num   = DW'(1) << (2 * F);
        div_den   = DW'((ny_q < 0) ? -ny_q : ny_q);
        div_iters = IW'(2 * F + 1);
      end
      gdr_pkg::OP_DIV_SPAN: begin
        div_start = 1'b1;
        div_num   = DW'(h) << F;
        div_den   = dist_q;
        div_iters = IW'(F + 12);
      end
      default: ;
    endcase
  end

  gdr_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Shared multiplier operand select
  logic signed [MW-1:0] ma, mb;
  logic [F:0] fr_x, fr_y;

  assign fr_x = (nx_q < 0) ? {1'b0, frx} : ((F + 1)'(1) << F) - {1'b0, frx};
  assign fr_y = (ny_q < 0) ? {1'b0, fry} : ((F + 1)'(1) << F) - {1'b0, fry};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      gdr_pkg::OP_MUL_KC:  begin ma = MW'(K);    mb = MW'(camx_q); end
      gdr_pkg::OP_MUL_DYT: begin ma = MW'(dy);   mb = MW'(t_q);    end
      gdr_pkg::OP_MUL_DXT: begin ma = MW'(dx);   mb = MW'(t_q);    end
      gdr_pkg::OP_MUL_RX2: begin ma = MW'(rx_q); mb = MW'(rx_q);   end
      gdr_pkg::OP_MUL_RY2: begin ma = MW'(ry_q); mb = MW'(ry_q);   end
      gdr_pkg::OP_MUL_SXH: begin
        ma = $signed(MW'(dxd_q >> F)); mb = $signed(MW'(fr_x));
      end
      gdr_pkg::OP_MUL_SXL: begin
        ma = $signed(MW'(dxd_q[F-1:0])); mb = $signed(MW'(fr_x));
      end
      gdr_pkg::OP_MUL_SYH: begin
        ma = $signed(MW'(dyd_q >> F)); mb = $signed(MW'(fr_y));
      end
      gdr_pkg::OP_MUL_SYL: begin
        ma = $signed(MW'(dyd_q[F-1:0])); mb = $signed(MW'(fr_y));
      end
      default: ;
    endcase
  end

  // Grid step: advance along the smaller side distance, ties go in y
  logic stepx;
  logic signed [CW-1:0] mx_d, my_d;
  logic [AW-1:0] raddr, waddr;
  logic we;

  assign stepx = sx_q < sy_q;
  always_comb begin
    mx_d = mx_q;
    my_d = my_q;
    if (stepx) mx_d = (nx_q < 0) ? mx_q - 1'b1 : mx_q + 1'b1;
    else       my_d = (ny_q < 0) ? my_q - 1'b1 : my_q + 1'b1;
  end

  assign raddr = AW'(AW'(mx_d) * AW'(MAP_SIZE) + AW'(my_d));
  assign waddr = AW'(AW'(in_item_i.cell_col) * AW'(MAP_SIZE) + AW'(in_item_i.cell_row));
  assign we    = cmd_i.take && (in_item_i.kind == gdr_pkg::KIND_WRITE) &&
                 (32'(in_item_i.cell_col) < MAP_SIZE) && (32'(in_item_i.cell_row) < MAP_SIZE);

  logic [3:0] code;
  gdr_ram #(.WIDTH(4), .DEPTH(MAP_SIZE * MAP_SIZE)) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_item_i.cell_code),
    .re_i    (cmd_i.op == gdr_pkg::OP_STEP),
    .raddr_i (raddr),
    .rdata_o (code)
  );

  // Square root step
  logic [SW-1:0] sq_sum;
  assign sq_sum = sq_res_q + sq_bit_q;

  // Span limits
  logic [12:0] h2;
  logic [10:0] hs;
  logic [11:0] sp2;
  logic signed [13:0] start_s;
  logic [12:0] end_s;
  logic [23:0] rgb;

  assign h2      = {h, 1'b0};
  assign hs      = h[11:1];
  assign sp2     = span_q[12:1];
  assign start_s = $signed({3'b0, hs}) - $signed({2'b0, sp2});
  assign end_s   = {1'b0, sp2} + {2'b0, hs};
  assign rgb     = gdr_pkg::color_f(code);

  // Miss beat: only the column is reported
  always_comb begin
    miss_item            = '0;
    miss_item.out_column = item_q.column;
  end

  // ---------------- operation execution ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_item_i;
    case (cmd_i.op)
      gdr_pkg::OP_MUL_KC, gdr_pkg::OP_MUL_DYT, gdr_pkg::OP_MUL_DXT,
      gdr_pkg::OP_MUL_RX2, gdr_pkg::OP_MUL_RY2, gdr_pkg::OP_MUL_SXH,
      gdr_pkg::OP_MUL_SXL, gdr_pkg::OP_MUL_SYH, gdr_pkg::OP_MUL_SYL: begin
        prod_q <= ma * mb;
      end
      gdr_pkg::OP_CAP_CAMX: begin
        if (div_done) camx_q <= (cdiff < 0) ? -$signed((F + 2)'(div_q))
                                            : $signed((F + 2)'(div_q));
        mx_q    <= $signed(CW'(pos_x_q[20:16]));
        my_q    <= $signed(CW'(pos_y_q[20:16]));
        steps_q <= '0;
        side_q  <= 1'b0;
        oob_q   <= 1'b0;
      end
      gdr_pkg::OP_T:  t_q  <= (F + 2)'(shr_f(prod_q));
      gdr_pkg::OP_RX: rx_q <= dx + (F + 3)'(shr_f(prod_q));
      gdr_pkg::OP_RY: ry_q <= dy - (F + 3)'(shr_f(prod_q));
      gdr_pkg::OP_ACC: acc_q <= SW'(prod_q);
      gdr_pkg::OP_SQ_INIT: begin
        sq_v_q   <= acc_q + SW'(prod_q);
        sq_res_q <= '0;
        sq_bit_q <= SW'(1) << (SW - 2);
      end
      gdr_pkg::OP_SQ_STEP: begin
        if (sq_bit_q != '0) begin
          if (sq_v_q >= sq_sum) begin
            sq_v_q   <= sq_v_q - sq_sum;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      gdr_pkg::OP_CAP_NX: begin
        if (div_done) nx_q <= (rx_q < 0) ? -$signed((F + 2)'(div_q))
                                         : $signed((F + 2)'(div_q));
      end
      gdr_pkg::OP_CAP_NY: begin
        if (div_done) ny_q <= (ry_q < 0) ? -$signed((F + 2)'(div_q))
                                         : $signed((F + 2)'(div_q));
      end
      gdr_pkg::OP_CAP_DX: begin
        if (div_done) dxd_q <= (nx_q == '0) ? (DW'(1) << (2 * F + 1)) : div_q;
      end
      gdr_pkg::OP_CAP_DY: begin
        if (div_done) dyd_q <= (ny_q == '0) ? (DW'(1) << (2 * F + 1)) : div_q;
      end
      gdr_pkg::OP_SXH: sx_q <= DW'(prod_q);
      gdr_pkg::OP_SXL: sx_q <= sx_q + DW'(prod_q >>> F);
      gdr_pkg::OP_SYH: sy_q <= DW'(prod_q);
      gdr_pkg::OP_SYL: sy_q <= sy_q + DW'(prod_q >>> F);
      gdr_pkg::OP_STEP: begin
        if (stepx) sx_q <= sx_q + dxd_q;
        else       sy_q <= sy_q + dyd_q;
        mx_q    <= mx_d;
        my_q    <= my_d;
        side_q  <= !stepx;
        steps_q <= steps_q + 1'b1;
        oob_q   <= (mx_d < 0) || (mx_d >= CW'(MAP_SIZE)) ||
                   (my_d < 0) || (my_d >= CW'(MAP_SIZE));
      end
      gdr_pkg::OP_DIST: dist_q <= side_q ? (sy_q - dyd_q) : (sx_q - dxd_q);
      gdr_pkg::OP_CAP_SPAN: begin
        if (div_done) begin
          span_q <= ((dist_q == '0) || (div_q > DW'(h2))) ? h2 : 13'(div_q);
        end
      end
      gdr_pkg::OP_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.out_column <= item_q.column;
          out_q.draw_start <= (start_s < 0) ? 11'd0 : 11'(start_s);
          out_q.draw_end   <= (end_s >= {1'b0, h}) ? 11'(h - 12'd1) : 11'(end_s);
          out_q.red        <= side_q ? {1'b0, rgb[23:17]} : rgb[23:16];
          out_q.green      <= side_q ? {1'b0, rgb[15:9]}  : rgb[15:8];
          out_q.blue       <= side_q ? {1'b0, rgb[7:1]}   : rgb[7:0];
          out_q.y_side     <= side_q;
          out_q.hit        <= 1'b1;
        end
      end
      gdr_pkg::OP_MISS: begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= miss_item;
        end
      end
      default: ;
    endcase
  end

  // Output beat valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.op == gdr_pkg::OP_FIN || cmd_i.op == gdr_pkg::OP_MISS) &&
                 (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  // Status back to the controller
  assign status_o.in_valid = in_valid_i;
  assign status_o.in_kind  = in_item_i.kind;
  assign status_o.div_done = div_done;
  assign status_o.sq_done  = (sq_bit_q == '0);
  assign status_o.len_zero = (sq_res_q == '0);
  assign status_o.cam_oob  = (32'(pos_x_q[20:16]) >= MAP_SIZE) ||
                             (32'(pos_y_q[20:16]) >= MAP_SIZE);
  assign status_o.step_lim = (steps_q > STEP_MAX);
  assign status_o.oob      = oob_q;
  assign status_o.code_nz  = (code != '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== sv/grid_dda_raycast_column_top.sv =====
// Grid ray caster, one wall span per cast beat. Map-write beats are written
// into the wall map as they are accepted. A cast walks the grid cell by cell
// and runs on the one-bit-per-cycle divider (six divisions) and the
// one-root-bit-per-cycle square root, one cast at a time; its last step waits
// until the output register is free for the receiver.
// Reset restores the camera and screen registers; the wall map is undefined
// until written and needs no clearing pass.
module grid_dda_raycast_column_top #(
  parameter int MAP_SIZE  = gdr_pkg::MAP_SIZE_DEF,
  parameter int FRAC_BITS = gdr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  gdr_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output gdr_pkg::out_item_t             out_item_o
);

  gdr_pkg::cmd_t    cmd;
  gdr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  gdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  gdr_dp #(.MAP_SIZE(MAP_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
